// ===== hdl/rbpw_pkg.sv =====
// ----------------------------------------------------------------------------
// rbpw_pkg
// Shared types and constants of the rectangle blit pixel writer.
// ----------------------------------------------------------------------------
package rbpw_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int ARGB_W     = 32;
	localparam int DATA_W     = 32;
	localparam int START_W    = 13;
	localparam int SPAN_REG_W = 13;
	localparam int PITCH_W    = 14;
	localparam int SCREEN_W   = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_COL    = 3'd0,
		REG_START_ROW    = 3'd1,
		REG_RECT_WIDTH   = 3'd2,
		REG_RECT_HEIGHT  = 3'd3,
		REG_LINE_BYTES   = 3'd4,
		REG_PIXEL_FORMAT = 3'd5,
		REG_SCREEN_BYTES = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [START_W-1:0] start_col;
		logic signed [START_W-1:0] start_row;
		logic [SPAN_REG_W-1:0]     rect_width;
		logic [SPAN_REG_W-1:0]     rect_height;
		logic [PITCH_W-1:0]        line_bytes;
		logic                      pixel_format;
		logic [SCREEN_W-1:0]       screen_bytes;
	} cfg_t;

endpackage

// ===== hdl/rbpw_ifs.sv =====
// ----------------------------------------------------------------------------
// rbpw channel interfaces
// Valid/ready channels for pixels in, writes out and register writes.
// ----------------------------------------------------------------------------
interface rbpw_pix_if;
	import rbpw_pkg::*;
	logic              valid;
	logic              ready;
	logic [ARGB_W-1:0] argb;
	modport source (output valid, output argb, input ready);
	modport sink (input valid, input argb, output ready);
endinterface

interface rbpw_wr_if #(parameter int ADDR_BITS = 24);
	import rbpw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 write_enable;
	logic [ADDR_BITS-1:0] write_addr;
	logic [DATA_W-1:0]    write_data;
	logic                 write_wide;
	logic                 last_pixel;
	modport source (output valid, output write_enable, output write_addr,
		output write_data, output write_wide, output last_pixel, input ready);
	modport sink (input valid, input write_enable, input write_addr,
		input write_data, input write_wide, input last_pixel, output ready);
endinterface

interface rbpw_cfg_if;
	import rbpw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rect_blit_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// rect_blit_pixel_writer
// Rectangle blit: ARGB pixels in raster order to framebuffer writes.
// ----------------------------------------------------------------------------
// cfg: register writes (index, data), always ready; write only while no pixel
//   is in flight. start_col/start_row carry origin plus pan.
// pix: one ARGB pixel per transfer, in raster order over the rectangle.
// wr:  one write per pixel: enable, byte address, 0RGB or RGB565 data, width
//   flag and a last flag on the final pixel of the rectangle.
// The pixel goes into an input register, the address multiply-add, bounds
//   check and repack run between that and the result register, so a result
//   is offered on wr from the result register once its pixel has passed the
//   input register, and it transfers when wr.ready is high.
// One pixel per cycle sustained while wr takes each write; each stage holds one pixel.
// When wr stalls the result register holds, the input register still takes
//   one more pixel, and pix.ready then drops until wr takes the result.
// Reset clears both stages, puts the column and row counters at the
//   rectangle's origin and loads the register reset values.
// ----------------------------------------------------------------------------
module rect_blit_pixel_writer #(
	parameter int COORD_BITS = 12,
	parameter int ADDR_BITS  = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	rbpw_cfg_if.sink  cfg,
	rbpw_pix_if.sink  pix,
	rbpw_wr_if.source wr
);
	import rbpw_pkg::*;

	cfg_t                  regs;
	logic                  adv;
	logic                  valid_s1;
	logic [ARGB_W-1:0]     argb_s1;
	logic [COORD_BITS-1:0] col_s1;
	logic [COORD_BITS-1:0] row_s1;
	logic                  last_s1;

	rbpw_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rbpw_walker #(
		.COORD_BITS (COORD_BITS)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.regs     (regs),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.argb_s1  (argb_s1),
		.col_s1   (col_s1),
		.row_s1   (row_s1),
		.last_s1  (last_s1)
	);

	rbpw_pack #(
		.COORD_BITS (COORD_BITS),
		.ADDR_BITS  (ADDR_BITS)
	) u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.valid_s1 (valid_s1),
		.argb_s1  (argb_s1),
		.col_s1   (col_s1),
		.row_s1   (row_s1),
		.last_s1  (last_s1),
		.adv      (adv),
		.wr       (wr)
	);

endmodule

// ===== hdl/rbpw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rbpw_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module rbpw_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	rbpw_cfg_if.sink      cfg,
	output rbpw_pkg::cfg_t regs
);
	import rbpw_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_col    <= '0;
			regs_q.start_row    <= '0;
			regs_q.rect_width   <= SPAN_REG_W'(1);
			regs_q.rect_height  <= SPAN_REG_W'(1);
			regs_q.line_bytes   <= '0;
			regs_q.pixel_format <= 1'b0;
			regs_q.screen_bytes <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_START_COL: begin
					regs_q.start_col <= cfg.data[START_W-1:0];
				end
				REG_START_ROW: begin
					regs_q.start_row <= cfg.data[START_W-1:0];
				end
				REG_RECT_WIDTH: begin
					regs_q.rect_width <= cfg.data[SPAN_REG_W-1:0];
				end
				REG_RECT_HEIGHT: begin
					regs_q.rect_height <= cfg.data[SPAN_REG_W-1:0];
				end
				REG_LINE_BYTES: begin
					regs_q.line_bytes <= cfg.data[PITCH_W-1:0];
				end
				REG_PIXEL_FORMAT: begin
					regs_q.pixel_format <= cfg.data[0];
				end
				REG_SCREEN_BYTES: begin
					regs_q.screen_bytes <= cfg.data[SCREEN_W-1:0];
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

endmodule

// ===== hdl/rbpw_walker.sv =====
// ----------------------------------------------------------------------------
// rbpw_walker
// Input register stage with the column and row counters of the rectangle.
// ----------------------------------------------------------------------------
module rbpw_walker #(
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rbpw_pix_if.sink                      pix,
	input  rbpw_pkg::cfg_t                regs,
	input  logic                          adv,
	output logic                          valid_s1,
	output logic [rbpw_pkg::ARGB_W-1:0]   argb_s1,
	output logic [COORD_BITS-1:0]         col_s1,
	output logic [COORD_BITS-1:0]         row_s1,
	output logic                          last_s1
);
	import rbpw_pkg::*;

	// wide enough for both the span register and 2^COORD_BITS
	localparam int CW = (COORD_BITS >= SPAN_REG_W) ? COORD_BITS + 1 : SPAN_REG_W;
	localparam logic [CW-1:0] SPAN_MAX = CW'(1) << COORD_BITS;

	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [CW-1:0]         w_ext;
	logic [CW-1:0]         h_ext;
	logic [CW-1:0]         w_eff;
	logic [CW-1:0]         h_eff;
	logic [CW-1:0]         col_inc;
	logic [CW-1:0]         row_inc;
	logic                  end_col;
	logic                  end_row;
	logic                  accept;

	always_comb begin
		w_ext = CW'(regs.rect_width);
		h_ext = CW'(regs.rect_height);
		// zero acts as one, oversize clamps to the counter range
		if (w_ext == '0) begin
			w_eff = CW'(1);
		end else if (w_ext > SPAN_MAX) begin
			w_eff = SPAN_MAX;
		end else begin
			w_eff = w_ext;
		end
		if (h_ext == '0) begin
			h_eff = CW'(1);
		end else if (h_ext > SPAN_MAX) begin
			h_eff = SPAN_MAX;
		end else begin
			h_eff = h_ext;
		end
		col_inc = CW'(col_q) + CW'(1);
		row_inc = CW'(row_q) + CW'(1);
		end_col = col_inc >= w_eff;
		end_row = row_inc >= h_eff;
	end

	assign pix.ready = !valid_s1 || adv;
	assign accept    = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (end_col) begin
					col_q <= '0;
					if (end_row) begin
						row_q <= '0;
					end else begin
						row_q <= row_inc[COORD_BITS-1:0];
					end
				end else begin
					col_q <= col_inc[COORD_BITS-1:0];
				end
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			argb_s1 <= pix.argb;
			col_s1  <= col_q;
			row_s1  <= row_q;
			last_s1 <= end_col && end_row;
		end
	end

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_col && end_row |=> col_q == '0 && row_q == '0)
		else $error("counters not back at origin after last pixel");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !end_col |=> col_q == $past(col_inc[COORD_BITS-1:0])
			&& row_q == $past(row_q))
		else $error("column step wrong inside a row");

endmodule

// ===== hdl/rbpw_pack.sv =====
// ----------------------------------------------------------------------------
// rbpw_pack
// Address calculation, bounds check, colour repack and result register.
// ----------------------------------------------------------------------------
module rbpw_pack #(
	parameter int COORD_BITS = 12,
	parameter int ADDR_BITS  = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rbpw_pkg::cfg_t                regs,
	input  logic                          valid_s1,
	input  logic [rbpw_pkg::ARGB_W-1:0]   argb_s1,
	input  logic [COORD_BITS-1:0]         col_s1,
	input  logic [COORD_BITS-1:0]         row_s1,
	input  logic                          last_s1,
	output logic                          adv,
	rbpw_wr_if.source                     wr
);
	import rbpw_pkg::*;

	// signed screen coordinate, start offset plus counter
	localparam int XW = ((COORD_BITS > START_W - 1) ? COORD_BITS : START_W - 1) + 2;
	localparam int PW = XW + PITCH_W + 1;
	localparam int LW = (PW + 1 > ADDR_BITS + 1) ? PW + 1 : ADDR_BITS + 1;

	logic signed [XW-1:0] x;
	logic signed [XW-1:0] y;
	logic signed [XW+1:0] xb;
	logic signed [PW-1:0] prod;
	logic [LW-1:0]        loc;
	logic                 in_bounds;
	logic                 en;
	logic                 wide;
	logic [DATA_W-1:0]    data;

	always_comb begin
		wide = regs.pixel_format;
		x    = XW'(regs.start_col) + XW'({1'b0, col_s1});
		y    = XW'(regs.start_row) + XW'({1'b0, row_s1});
		if (wide) begin
			xb = {x, 2'b00};
		end else begin
			xb = {x[XW-1], x, 1'b0};
		end
		prod      = PW'(y) * PW'(signed'({1'b0, regs.line_bytes}));
		loc       = LW'(xb) + LW'(prod);
		in_bounds = !loc[LW-1] && (loc < LW'(regs.screen_bytes));
		en        = in_bounds && (argb_s1[31:24] != 8'h00);
		if (wide) begin
			data = {8'h00, argb_s1[23:0]};
		end else begin
			data = {16'h0000, argb_s1[23:19], argb_s1[15:10], argb_s1[7:3]};
		end
	end

	assign adv = !wr.valid || wr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr.valid <= 1'b0;
		end else if (adv) begin
			wr.valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			wr.write_enable <= en;
			wr.write_addr   <= en ? loc[ADDR_BITS-1:0] : '0;
			wr.write_data   <= data;
			wr.write_wide   <= wide;
			wr.last_pixel   <= last_s1;
		end
	end

	a_off_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid && !wr.write_enable |-> wr.write_addr == '0)
		else $error("suppressed write carries an address");

	a_on_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid && wr.write_enable |-> wr.write_addr < regs.screen_bytes)
		else $error("enabled write beyond screen size");

	a_narrow_upper: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid && !wr.write_wide |-> wr.write_data[31:16] == 16'h0000)
		else $error("rgb565 write has upper bits set");

endmodule
